### rtl/pwfc_pkg.sv
// pwfc_pkg: shared widths, reset values, register indexes and the config bundle
// for the wall-following PID controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwfc_pkg;

  // proximity samples and the Q12.4 average
  localparam int IN_W        = 12;
  localparam int RAW_W       = 15;   // 3*front + front_side + side
  localparam int AVG_DVD_W   = 19;   // raw * 16
  localparam int AVG_W       = 16;   // floor(raw*16/5) <= 65520
  localparam int AVG_DIV     = 5;

  // error path
  localparam int ERR_W       = 18;   // signed Q12.4 error
  localparam int ERR_MAG_MAX = 65520;
  localparam int DIFF_MAG_MAX = 131040;
  localparam int DIFF_MAG_W  = 17;
  localparam int D_SCALE     = 1000;
  localparam int DER_DVD_W   = 27;   // |diff| * 1000
  localparam int I_SCALE     = 1000;

  // shared serial divider
  localparam int DIV_QW      = 63;   // widest dividend: gain * |integral|
  localparam int DIV_DW      = 10;   // holds 5, TICK_MS and 1000
  localparam int DIV_SW      = $clog2(DIV_QW + 1);

  // gains, integral and the correction sum
  localparam int GAIN_W      = 24;
  localparam int INTEG_W     = 40;
  localparam int IQ_W        = 55;   // signed gain*integral/1000
  localparam int SUM_W       = 56;
  localparam int DS_FRAC     = 16;
  localparam int SPD_W       = 16;
  localparam int SPD_CFG_W   = 15;
  localparam int DS_UNITY    = 4096; // 1.0 in Q4.12

  // mode tracking
  localparam int CNT_W       = 9;
  localparam int HOLD_W      = 8;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int TICK_MS_DEF = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WALL_TARGET    = 3'd0,
    REG_PROX_THRESHOLD = 3'd1,
    REG_HOLD_TICKS     = 3'd2,
    REG_CRUISE_SPEED   = 3'd3,
    REG_WALL_SPEED     = 3'd4,
    REG_P_GAIN         = 3'd5,
    REG_D_GAIN         = 3'd6,
    REG_I_GAIN         = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [IN_W-1:0]      wall_target;
    logic [IN_W-1:0]      prox_threshold;
    logic [HOLD_W-1:0]    hold_ticks;
    logic [SPD_CFG_W-1:0] cruise_speed;
    logic [SPD_CFG_W-1:0] wall_speed;
    logic [GAIN_W-1:0]    p_gain;
    logic [GAIN_W-1:0]    d_gain;
    logic [GAIN_W-1:0]    i_gain;
  } cfg_t;

  localparam logic [IN_W-1:0]      RST_WALL_TARGET    = 12'd700;
  localparam logic [IN_W-1:0]      RST_PROX_THRESHOLD = 12'd50;
  localparam logic [HOLD_W-1:0]    RST_HOLD_TICKS     = 8'd10;
  localparam logic [SPD_CFG_W-1:0] RST_CRUISE_SPEED   = 15'd8192;
  localparam logic [SPD_CFG_W-1:0] RST_WALL_SPEED     = 15'd12288;
  localparam logic [GAIN_W-1:0]    RST_P_GAIN         = 24'd26844;
  localparam logic [GAIN_W-1:0]    RST_D_GAIN         = 24'd9395;
  localparam logic [GAIN_W-1:0]    RST_I_GAIN         = 24'd2983;

endpackage

`default_nettype wire

### rtl/pwfc_cfg_regs.sv
// pwfc_cfg_regs: configuration register file, written through a plain write port.
// Depends on pwfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwfc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pwfc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [pwfc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pwfc_pkg::cfg_t                        cfg
);

  pwfc_pkg::cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wall_target    <= pwfc_pkg::RST_WALL_TARGET;
      regs.prox_threshold <= pwfc_pkg::RST_PROX_THRESHOLD;
      regs.hold_ticks     <= pwfc_pkg::RST_HOLD_TICKS;
      regs.cruise_speed   <= pwfc_pkg::RST_CRUISE_SPEED;
      regs.wall_speed     <= pwfc_pkg::RST_WALL_SPEED;
      regs.p_gain         <= pwfc_pkg::RST_P_GAIN;
      regs.d_gain         <= pwfc_pkg::RST_D_GAIN;
      regs.i_gain         <= pwfc_pkg::RST_I_GAIN;
    end else if (cfg_we) begin
      // values are truncated to the register width
      case (pwfc_pkg::cfg_idx_t'(cfg_addr))
        pwfc_pkg::REG_WALL_TARGET:    regs.wall_target    <= cfg_data[pwfc_pkg::IN_W-1:0];
        pwfc_pkg::REG_PROX_THRESHOLD: regs.prox_threshold <= cfg_data[pwfc_pkg::IN_W-1:0];
        pwfc_pkg::REG_HOLD_TICKS:     regs.hold_ticks     <= cfg_data[pwfc_pkg::HOLD_W-1:0];
        pwfc_pkg::REG_CRUISE_SPEED:   regs.cruise_speed   <= cfg_data[pwfc_pkg::SPD_CFG_W-1:0];
        pwfc_pkg::REG_WALL_SPEED:     regs.wall_speed     <= cfg_data[pwfc_pkg::SPD_CFG_W-1:0];
        pwfc_pkg::REG_P_GAIN:         regs.p_gain         <= cfg_data[pwfc_pkg::GAIN_W-1:0];
        pwfc_pkg::REG_D_GAIN:         regs.d_gain         <= cfg_data[pwfc_pkg::GAIN_W-1:0];
        pwfc_pkg::REG_I_GAIN:         regs.i_gain         <= cfg_data[pwfc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pwfc_serial_div.sv
// pwfc_serial_div: unsigned restoring divider, one quotient bit per cycle.
// Dividend arrives left-aligned; when done pulses the quotient sits in the low bits.
`timescale 1ns / 1ps
`default_nettype none

module pwfc_serial_div #(
  parameter int QW = pwfc_pkg::DIV_QW,
  parameter int DW = pwfc_pkg::DIV_DW
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [QW-1:0]             dividend,
  input  wire logic [DW-1:0]             divisor,
  input  wire logic [$clog2(QW+1)-1:0]   steps,
  output logic                           done,
  output logic [QW-1:0]                  quotient
);

  localparam int SW = $clog2(QW + 1);

  logic [QW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [SW-1:0] cnt;
  logic          busy;

  logic [DW:0]   trial;
  logic [DW:0]   tdiff;
  logic          ge;
  logic [DW-1:0] rem_next;

  assign trial    = {rem, quo[QW-1]};
  assign tdiff    = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign rem_next = ge ? tdiff[DW-1:0] : trial[DW-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[QW-2:0], ge};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

### rtl/pwfc_serial_mul.sv
// pwfc_serial_mul: shift-add multiplier, signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle from the top bit down. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pwfc_serial_mul #(
  parameter int AW = 18,
  parameter int BW = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [AW-1:0]  mcand,
  input  wire logic [BW-1:0]         mplr,
  output logic                       done,
  output logic signed [AW+BW-1:0]    prod
);

  localparam int PW = AW + BW;
  localparam int SW = $clog2(BW + 1);

  logic signed [AW-1:0] a_r;
  logic [BW-1:0]        bsh;
  logic signed [PW-1:0] acc;
  logic [SW-1:0]        cnt;
  logic                 busy;
  logic signed [PW-1:0] addend;

  assign addend = bsh[BW-1] ? PW'(a_r) : PW'(0);
  assign prod   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SW'(BW);
      end else if (busy) begin
        cnt <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Horner form: acc = 2*acc + bit*a
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= mcand;
      bsh <= mplr;
      acc <= '0;
    end else if (busy) begin
      bsh <= {bsh[BW-2:0], 1'b0};
      acc <= (acc <<< 1) + addend;
    end
  end

endmodule

`default_nettype wire

### rtl/pid_wall_follow_controller_top.sv
// pid_wall_follow_controller_top: wall-following PID controller, sequencer and datapath.
// Depends on pwfc_pkg, pwfc_cfg_regs, pwfc_serial_div and pwfc_serial_mul.
//
// Usage
//  One input word per control tick on s_*: the four right-side proximity samples.
//  One result word per input word on m_*: wheel speeds and correction in tdata,
//  mode and PID-step flags in tuser.
//  Registers are written on cfg_* (enable, index, data) while the block is idle.
// Timing
//  Items are handled one at a time. The time from acceptance to result is set by the
//  shared bit-serial divider (19 steps for the average, 27 for the derivative, 63 for
//  the integral term) and the 24-step serial gain multipliers.
//  s_tready is high only while the sequencer is idle.
// Reset
//  rst (synchronous) restores register defaults, cruise mode, zero hold count,
//  zero previous error and zero integral, and empties the output register.
// Back-pressure
//  The result sits in an output register; the next word can be accepted and worked on
//  while it waits. A finished result holds in the sequencer until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module pid_wall_follow_controller_top #(
  parameter int TICK_MS = pwfc_pkg::TICK_MS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // fields low to high: prox_front, prox_front_side, prox_side, prox_back
  input  wire logic [47:0]                      s_tdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // fields low to high: left_speed, right_speed, correction
  output logic [47:0]                           m_tdata,
  // fields low to high: pid_mode, pid_applied
  output logic [1:0]                            m_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_we,
  input  wire logic [pwfc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [pwfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // widths that follow from the tick length
  localparam int DER_MAG_W = $clog2(pwfc_pkg::DIFF_MAG_MAX * pwfc_pkg::D_SCALE / TICK_MS + 1);
  localparam int DERIV_W   = DER_MAG_W + 1;
  localparam int INC_W     = $clog2(pwfc_pkg::ERR_MAG_MAX * TICK_MS + 1) + 1;
  localparam int QW        = pwfc_pkg::DIV_QW;
  localparam int DW        = pwfc_pkg::DIV_DW;
  localparam int SW        = pwfc_pkg::DIV_SW;
  localparam int GW        = pwfc_pkg::GAIN_W;
  localparam int IW        = pwfc_pkg::INTEG_W;
  localparam int EW        = pwfc_pkg::ERR_W;
  localparam int SAT_W     = pwfc_pkg::SUM_W - pwfc_pkg::DS_FRAC;
  localparam int PW_P      = EW + GW;
  localparam int PW_D      = DERIV_W + GW;
  localparam int PW_I      = IW + 1 + GW;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_AVG   = 15'b000000000000010,
    S_MODE  = 15'b000000000000100,
    S_ERR   = 15'b000000000001000,
    S_DIFF  = 15'b000000000010000,
    S_DERIV = 15'b000000000100000,
    S_MULGO = 15'b000000001000000,
    S_MUL   = 15'b000000010000000,
    S_IGO   = 15'b000000100000000,
    S_IDIV  = 15'b000001000000000,
    S_SUM1  = 15'b000010000000000,
    S_SUM2  = 15'b000100000000000,
    S_DSAT  = 15'b001000000000000,
    S_SPEED = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  function automatic logic signed [pwfc_pkg::SPD_W-1:0] sat_spd(input logic signed [SAT_W-1:0] v);
    logic signed [pwfc_pkg::SPD_W-1:0] r;
    if (v > SAT_W'(32767))       r = 16'sh7FFF;
    else if (v < -SAT_W'(32768)) r = 16'sh8000;
    else                         r = v[pwfc_pkg::SPD_W-1:0];
    return r;
  endfunction

  state_t state;
  pwfc_pkg::cfg_t cfg;

  // model state
  logic                           follow_mode;
  logic [pwfc_pkg::CNT_W-1:0]     below_count;
  logic signed [EW-1:0]           prev_error;
  logic signed [IW-1:0]           integ;

  // working registers
  logic [pwfc_pkg::AVG_W-1:0]     avg_r;
  logic signed [EW-1:0]           err_r;
  logic                           diff_neg_r;
  logic signed [INC_W-1:0]        incr_r;
  logic signed [DERIV_W-1:0]      deriv_r;
  logic signed [pwfc_pkg::IQ_W-1:0]  iq_r;
  logic signed [pwfc_pkg::SUM_W-1:0] s1_r;
  logic signed [pwfc_pkg::SUM_W-1:0] sum_r;
  logic signed [pwfc_pkg::SPD_W-1:0] ds_r;

  // result staging
  logic signed [pwfc_pkg::SPD_W-1:0] res_left, res_right, res_corr;
  logic                              res_mode, res_applied;

  // shared divider
  logic            div_start, div_done;
  logic [QW-1:0]   div_dividend, div_quo;
  logic [DW-1:0]   div_divisor;
  logic [SW-1:0]   div_steps;

  // gain lanes
  logic                  mul_start, p_done, d_done, i_done, mul_done;
  logic signed [PW_P-1:0] p_prod;
  logic signed [PW_D-1:0] d_prod;
  logic signed [PW_I-1:0] i_prod;
  logic [IW-1:0]          integ_mag;

  // average
  logic [pwfc_pkg::RAW_W-1:0]     raw;
  logic [pwfc_pkg::AVG_DVD_W-1:0] avg_dvd;

  // mode decision
  logic [pwfc_pkg::AVG_W-1:0]     thr;
  logic                           below, above;
  logic                           mode_next;
  logic [pwfc_pkg::CNT_W-1:0]     cnt_next;

  // derivative dividend
  logic signed [EW:0]              diff;
  logic [EW:0]                     diff_abs;
  logic [pwfc_pkg::DER_DVD_W-1:0]  der_dvd;

  // integral update
  logic signed [IW:0]              isum;
  logic signed [IW-1:0]            integ_next;

  // correction and speeds
  logic signed [SAT_W-1:0]         ds_q;
  logic                            ds_big;
  logic signed [pwfc_pkg::SPD_W:0] base17, right17, left17;

  logic out_load;

  pwfc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  assign s_tready = (state == S_IDLE);

  // weights 3,1,1,0; back sample is not used
  assign raw = pwfc_pkg::RAW_W'({s_tdata[11:0], 1'b0}) + pwfc_pkg::RAW_W'(s_tdata[11:0])
             + pwfc_pkg::RAW_W'(s_tdata[23:12]) + pwfc_pkg::RAW_W'(s_tdata[35:24]);
  assign avg_dvd = {raw, 4'b0000};

  assign diff     = (EW+1)'(err_r) - (EW+1)'(prev_error);
  assign diff_abs = diff[EW] ? (EW+1)'(-diff) : (EW+1)'(diff);
  assign der_dvd  = pwfc_pkg::DER_DVD_W'(diff_abs[pwfc_pkg::DIFF_MAG_W-1:0])
                  * pwfc_pkg::DER_DVD_W'(pwfc_pkg::D_SCALE);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {avg_dvd, {(QW - pwfc_pkg::AVG_DVD_W){1'b0}}};
    div_divisor  = DW'(pwfc_pkg::AVG_DIV);
    div_steps    = SW'(pwfc_pkg::AVG_DVD_W);
    case (state)
      S_IDLE: begin
        div_start = s_tvalid;
      end
      S_DIFF: begin
        div_start    = 1'b1;
        div_dividend = {der_dvd, {(QW - pwfc_pkg::DER_DVD_W){1'b0}}};
        div_divisor  = DW'(TICK_MS);
        div_steps    = SW'(pwfc_pkg::DER_DVD_W);
      end
      S_IGO: begin
        div_start    = 1'b1;
        div_dividend = i_prod[QW-1:0];
        div_divisor  = DW'(pwfc_pkg::I_SCALE);
        div_steps    = SW'(QW);
      end
      default: ;
    endcase
  end

  pwfc_serial_div #(.QW(QW), .DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  // i-term works on |integral|; the sign is put back after the /1000
  assign integ_mag = integ[IW-1] ? IW'(-integ) : IW'(integ);
  assign mul_start = (state == S_MULGO);
  assign mul_done  = p_done & d_done & i_done;

  pwfc_serial_mul #(.AW(EW), .BW(GW)) u_mul_p (
    .clk (clk), .rst (rst), .start (mul_start),
    .mcand (err_r), .mplr (cfg.p_gain), .done (p_done), .prod (p_prod)
  );

  pwfc_serial_mul #(.AW(DERIV_W), .BW(GW)) u_mul_d (
    .clk (clk), .rst (rst), .start (mul_start),
    .mcand (deriv_r), .mplr (cfg.d_gain), .done (d_done), .prod (d_prod)
  );

  pwfc_serial_mul #(.AW(IW + 1), .BW(GW)) u_mul_i (
    .clk (clk), .rst (rst), .start (mul_start),
    .mcand ($signed({1'b0, integ_mag})), .mplr (cfg.i_gain), .done (i_done), .prod (i_prod)
  );

  // presence and hold-off count
  assign thr   = {cfg.prox_threshold, 4'b0000};
  assign below = (avg_r < thr);
  assign above = (avg_r > thr);

  always_comb begin
    mode_next = 1'b1;
    cnt_next  = '0;
    if (below) begin
      mode_next = follow_mode;
      cnt_next  = below_count + pwfc_pkg::CNT_W'(1);
      if (below_count > pwfc_pkg::CNT_W'(cfg.hold_ticks)) begin
        mode_next = 1'b0;
        cnt_next  = '0;
      end
    end
  end

  // integral += err*TICK_MS, clamped to 40 bits
  assign isum = (IW+1)'(integ) + (IW+1)'(incr_r);
  always_comb begin
    integ_next = isum[IW-1:0];
    if (isum[IW] != isum[IW-1]) integ_next = isum[IW] ? {1'b1, {(IW-1){1'b0}}}
                                                      : {1'b0, {(IW-1){1'b1}}};
  end

  // sum/65536 rounded toward zero
  assign ds_q = sum_r[pwfc_pkg::SUM_W-1:pwfc_pkg::DS_FRAC]
              + SAT_W'(sum_r[pwfc_pkg::SUM_W-1] && (|sum_r[pwfc_pkg::DS_FRAC-1:0]));

  assign ds_big  = (ds_r > 16'(pwfc_pkg::DS_UNITY)) || (ds_r < -16'(pwfc_pkg::DS_UNITY));
  assign base17  = ds_big ? 17'sd0 : $signed({2'b00, cfg.wall_speed});
  assign right17 = base17 + 17'(ds_r);
  assign left17  = base17 - 17'(ds_r);

  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // sequencer and model state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      follow_mode <= 1'b0;
      below_count <= '0;
      prev_error  <= '0;
      integ       <= '0;
    end else begin
      case (state)
        S_IDLE:  if (s_tvalid) state <= S_AVG;
        S_AVG:   if (div_done) state <= S_MODE;
        S_MODE: begin
          follow_mode <= mode_next;
          below_count <= cnt_next;
          state       <= (mode_next && above) ? S_ERR : S_OUT;
        end
        S_ERR:   state <= S_DIFF;
        S_DIFF: begin
          prev_error <= err_r;
          state      <= S_DERIV;
        end
        S_DERIV: begin
          if (div_done) begin
            integ <= integ_next;
            state <= S_MULGO;
          end
        end
        S_MULGO: state <= S_MUL;
        S_MUL:   if (mul_done) state <= S_IGO;
        S_IGO:   state <= S_IDIV;
        S_IDIV:  if (div_done) state <= S_SUM1;
        S_SUM1:  state <= S_SUM2;
        S_SUM2:  state <= S_DSAT;
        S_DSAT:  state <= S_SPEED;
        S_SPEED: state <= S_OUT;
        S_OUT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_AVG: begin
        if (div_done) avg_r <= div_quo[pwfc_pkg::AVG_W-1:0];
      end
      S_MODE: begin
        res_mode    <= mode_next;
        res_applied <= 1'b0;
        res_corr    <= '0;
        if (!mode_next) begin
          res_left  <= $signed({1'b0, cfg.cruise_speed});
          res_right <= $signed({1'b0, cfg.cruise_speed});
        end else begin
          // following but not above threshold: wheels stopped
          res_left  <= '0;
          res_right <= '0;
        end
      end
      S_ERR: begin
        err_r <= $signed({2'b00, avg_r}) - $signed({2'b00, cfg.wall_target, 4'b0000});
      end
      S_DIFF: begin
        diff_neg_r <= diff[EW];
        incr_r     <= INC_W'(err_r) * INC_W'(TICK_MS);
      end
      S_DERIV: begin
        if (div_done) begin
          deriv_r <= diff_neg_r ? -$signed({1'b0, div_quo[DER_MAG_W-1:0]})
                                :  $signed({1'b0, div_quo[DER_MAG_W-1:0]});
        end
      end
      S_IDIV: begin
        if (div_done) begin
          iq_r <= integ[IW-1] ? -$signed({1'b0, div_quo[pwfc_pkg::IQ_W-2:0]})
                              :  $signed({1'b0, div_quo[pwfc_pkg::IQ_W-2:0]});
        end
      end
      S_SUM1:  s1_r  <= pwfc_pkg::SUM_W'(p_prod) + pwfc_pkg::SUM_W'(d_prod);
      S_SUM2:  sum_r <= s1_r + pwfc_pkg::SUM_W'(iq_r);
      S_DSAT:  ds_r  <= sat_spd(ds_q);
      S_SPEED: begin
        res_right   <= sat_spd(SAT_W'(right17));
        res_left    <= sat_spd(SAT_W'(left17));
        res_corr    <= ds_r;
        res_applied <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res_corr, res_right, res_left};
      m_tuser <= {res_applied, res_mode};
    end
  end

  // a PID step only runs in following mode
  a_applied_needs_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("pid_applied set outside following mode");

  // no correction is reported without a PID step
  a_corr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[47:32] == 16'h0000)
    else $error("correction non-zero without PID step");

  // cruise mode drives both wheels alike
  a_cruise_equal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == m_tdata[31:16])
    else $error("cruise speeds differ");

  // an accepted word takes the sequencer out of idle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while busy");

endmodule

`default_nettype wire
